// ===== sv/att_pkg.sv =====
// shared types and constants of the allocation tracking table
// no dependencies

package att_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_BITS = 48;
	localparam int REQ_ADDR_W = 48;
	localparam int ENTRY_ADDR_W = (ADDR_BITS < REQ_ADDR_W) ? ADDR_BITS : REQ_ADDR_W;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int UNIT_SHIFT = 10;
	localparam int UNIT_STEPS = 6;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_DOUBLE_FREE = 2'd1;
	localparam logic [1:0] STAT_UNKNOWN = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [47:0] base_address;
		logic [31:0] elem_bytes;
		logic [31:0] elem_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] chunk_bytes;
		logic [63:0] bytes_in_use;
		logic [9:0]  scaled_total;
		logic [2:0]  unit_index;
	} rsp_t;

	typedef struct packed {
		logic [ENTRY_ADDR_W-1:0] addr;
		logic [63:0]             bytes;
		logic                    freed;
	} entry_t;

	typedef struct packed {
		logic                    valid;
		logic [ENTRY_ADDR_W-1:0] addr;
		logic [CNT_W-1:0]        remaining;
		logic                    hit;
		logic                    freed_before;
		logic [63:0]             bytes;
	} token_t;

endpackage

// ===== sv/allocation_tracking_table_core.sv =====
// top level of the allocation tracking table: control, totals and result register
// depends on att_pkg and att_chain

// One request is handled at a time. An allocate passes four steps from acceptance
// to a loaded result: capture, a 32x32 multiply, the saturating total update, and
// the result register. A free sends a search token through the row of TABLE_DEPTH
// cells, one cell per cycle with the newest entry first; the token always walks the
// whole row. The next request is taken once the previous result sits in the output
// register, even if it is not yet taken. Table entries need no clearing after reset.

module allocation_tracking_table_core import att_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ALLOC,
		S_SEARCH,
		S_RESULT
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [63:0]      total_q;
	logic [63:0]      bytes_q;
	logic [1:0]       status_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             accept;
	logic             full;
	logic             shift_en;
	logic             rsp_load;
	logic [64:0]      sum;
	entry_t           new_ent;
	token_t           tok_in;
	token_t           tok_out;
	logic [63:0]      shifted;
	logic [9:0]       scaled;
	logic [2:0]       unit;

	assign req_ready = (state_q == S_IDLE);
	assign accept = req_valid && req_ready;
	assign full = (count_q == CNT_W'(TABLE_DEPTH));
	assign shift_en = (state_q == S_ALLOC) && !full;
	assign rsp_load = (state_q == S_RESULT) && (!rsp_valid_q || rsp_ready);
	assign sum = {1'b0, total_q} + {1'b0, bytes_q};

	assign new_ent.addr = req_q.base_address[ENTRY_ADDR_W-1:0];
	assign new_ent.bytes = bytes_q;
	assign new_ent.freed = 1'b0;

	always_comb begin
		tok_in = '0;
		tok_in.valid = accept && (req.req_type == REQ_FREE);
		tok_in.addr = req.base_address[ENTRY_ADDR_W-1:0];
		tok_in.remaining = count_q;
	end

	att_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (shift_en),
		.new_ent  (new_ent),
		.tok_in   (tok_in),
		.tok_out  (tok_out)
	);

	// unit scaling of the total
	always_comb begin
		unit = '0;
		scaled = total_q[9:0];
		for (int k = 1; k <= UNIT_STEPS; k++) begin
			shifted = total_q >> (UNIT_SHIFT * k);
			if (shifted != '0) begin
				unit = 3'(k);
				scaled = shifted[9:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (req.req_type == REQ_FREE) ? S_SEARCH : S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ALLOC;
				end
				S_ALLOC: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
						total_q <= sum[64] ? '1 : sum[63:0];
					end
					state_q <= S_RESULT;
				end
				S_SEARCH: begin
					if (tok_out.valid) begin
						if (tok_out.hit && !tok_out.freed_before) begin
							total_q <= (total_q > tok_out.bytes) ?
								total_q - tok_out.bytes : '0;
						end
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_MUL) begin
			bytes_q <= 64'(req_q.elem_bytes) * 64'(req_q.elem_count);
		end
		if (state_q == S_ALLOC) begin
			status_q <= full ? STAT_FULL : STAT_OK;
		end
		if ((state_q == S_SEARCH) && tok_out.valid) begin
			if (!tok_out.hit) begin
				status_q <= STAT_UNKNOWN;
				bytes_q <= '0;
			end else begin
				status_q <= tok_out.freed_before ? STAT_DOUBLE_FREE : STAT_OK;
				bytes_q <= tok_out.bytes;
			end
		end
		if (rsp_load) begin
			rsp_q.status <= status_q;
			rsp_q.chunk_bytes <= bytes_q;
			rsp_q.bytes_in_use <= total_q;
			rsp_q.scaled_total <= scaled;
			rsp_q.unit_index <= unit;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_token_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tok_out.valid |-> (state_q == S_SEARCH))
		else $error("search token left the row outside a free");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("allocation did not take one entry");

	a_free_total_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH && tok_out.valid && !(tok_out.hit && !tok_out.freed_before))
		|=> $stable(total_q))
		else $error("total changed on a failed free");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> (state_q == S_IDLE))
		else $error("control did not return to idle after the result");

endmodule

// ===== sv/att_cell.sv =====
// one table entry with its share of the free search
// depends on att_pkg

module att_cell import att_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift_en,
	input  entry_t ent_in,
	output entry_t ent_out,
	input  token_t tok_in,
	output token_t tok_out
);

	entry_t ent_q;
	token_t tok_q;
	logic   active;
	logic   match;

	assign active = tok_in.valid && (tok_in.remaining != '0);
	assign match = active && !tok_in.hit && (tok_in.addr == ent_q.addr);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			ent_q <= ent_in;
		end else if (match) begin
			ent_q.freed <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.addr <= tok_in.addr;
			tok_q.remaining <= active ? tok_in.remaining - CNT_W'(1) : tok_in.remaining;
			if (match) begin
				tok_q.hit <= 1'b1;
				tok_q.freed_before <= ent_q.freed;
				tok_q.bytes <= ent_q.bytes;
			end else begin
				tok_q.hit <= tok_in.hit;
				tok_q.freed_before <= tok_in.freed_before;
				tok_q.bytes <= tok_in.bytes;
			end
		end
	end

	assign ent_out = ent_q;
	assign tok_out = tok_q;

endmodule

// ===== sv/att_chain.sv =====
// row of table cells, newest entry in cell zero
// depends on att_pkg and att_cell

module att_chain import att_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift_en,
	input  entry_t new_ent,
	input  token_t tok_in,
	output token_t tok_out
);

	entry_t ent[TABLE_DEPTH];
	token_t tok[TABLE_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			att_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.ent_in   (new_ent),
				.ent_out  (ent[i]),
				.tok_in   (tok_in),
				.tok_out  (tok[i])
			);
		end else begin : g_body
			att_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.ent_in   (ent[i-1]),
				.ent_out  (ent[i]),
				.tok_in   (tok[i-1]),
				.tok_out  (tok[i])
			);
		end
	end

	assign tok_out = tok[TABLE_DEPTH-1];

endmodule

// ===== bench/att_ledger_pkg.sv =====
`timescale 1ns / 100ps
// allocation ledger used by the testbench: mirrors the table and the live byte total
// and checks every response against the queue of predicted reports; needs att_pkg

package att_ledger_pkg;

	import att_pkg::*;

	class heap_ledger;
		logic [ENTRY_ADDR_W-1:0] slot_addr [TABLE_DEPTH];
		logic [63:0]             slot_bytes [TABLE_DEPTH];
		bit                      slot_freed [TABLE_DEPTH];
		int unsigned             slots_used;
		logic [63:0]             live_bytes;
		rsp_t                    due_reports [$];
		int unsigned             faults;

		function new();
			slots_used = 0;
			live_bytes = '0;
			faults = 0;
		endfunction

		function void report(logic [1:0] st, logic [63:0] bytes);
			rsp_t        e;
			logic [63:0] v;
			int unsigned u;
			v = live_bytes;
			u = 0;
			while ((v >> UNIT_SHIFT) != 0) begin
				v = v >> UNIT_SHIFT;
				u++;
			end
			e.status = st;
			e.chunk_bytes = bytes;
			e.bytes_in_use = live_bytes;
			e.scaled_total = v[9:0];
			e.unit_index = u[2:0];
			due_reports.push_back(e);
		endfunction

		function void book(req_t r);
			logic [63:0]             size;
			logic [ENTRY_ADDR_W-1:0] a;
			int                      i;
			a = r.base_address[ENTRY_ADDR_W-1:0];
			if (r.req_type == REQ_ALLOC) begin
				size = {32'd0, r.elem_bytes} * {32'd0, r.elem_count};
				if (slots_used >= TABLE_DEPTH) begin
					report(STAT_FULL, size);
					return;
				end
				slot_addr[slots_used] = a;
				slot_bytes[slots_used] = size;
				slot_freed[slots_used] = 1'b0;
				slots_used++;
				if (live_bytes > ~size)
					live_bytes = '1;
				else
					live_bytes = live_bytes + size;
				report(STAT_OK, size);
				return;
			end
			for (i = int'(slots_used) - 1; i >= 0; i--) begin
				if (slot_addr[i] == a) begin
					if (slot_freed[i]) begin
						report(STAT_DOUBLE_FREE, slot_bytes[i]);
						return;
					end
					slot_freed[i] = 1'b1;
					live_bytes = (live_bytes > slot_bytes[i]) ? live_bytes - slot_bytes[i] : '0;
					report(STAT_OK, slot_bytes[i]);
					return;
				end
			end
			report(STAT_UNKNOWN, '0);
		endfunction

		function void audit(rsp_t got);
			rsp_t e;
			if (due_reports.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected response: status %0d bytes_in_use %h",
						got.status, got.bytes_in_use);
				return;
			end
			e = due_reports.pop_front();
			if (got.status !== e.status || got.chunk_bytes !== e.chunk_bytes ||
					got.bytes_in_use !== e.bytes_in_use ||
					got.scaled_total !== e.scaled_total ||
					got.unit_index !== e.unit_index) begin
				faults++;
				if (faults <= 10)
					$display({"mismatch (expected/actual): status %0d/%0d chunk_bytes %h/%h",
						" bytes_in_use %h/%h scaled_total %0d/%0d unit_index %0d/%0d"},
						e.status, got.status, e.chunk_bytes, got.chunk_bytes,
						e.bytes_in_use, got.bytes_in_use, e.scaled_total, got.scaled_total,
						e.unit_index, got.unit_index);
			end
		endfunction
	endclass

endpackage

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// top of the allocation tracking table bench: clock, reset, request and response drivers
// depends on att_pkg, att_ledger_pkg and allocation_tracking_table_core

module testbench;

	import att_pkg::*;
	import att_ledger_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	heap_ledger  ledger;
	logic [47:0] issued_addrs [$];
	int unsigned reqs_sent = 0;
	int unsigned rsps_seen = 0;

	always #6 clk = ~clk;

	allocation_tracking_table_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	function automatic req_t make_req(logic t, logic [47:0] a, logic [31:0] b, logic [31:0] c);
		req_t r;
		r.req_type = t;
		r.base_address = a;
		r.elem_bytes = b;
		r.elem_count = c;
		return r;
	endfunction

	function automatic req_t random_req();
		req_t        r;
		int unsigned pick;
		int unsigned alloc_pct;
		r.base_address[47:32] = 16'($urandom_range(16'hFFFF));
		r.base_address[31:0] = $urandom;
		r.elem_bytes = $urandom;
		r.elem_count = $urandom;
		alloc_pct = (issued_addrs.size() < TABLE_DEPTH) ? 30 : 12;
		if ($urandom_range(99) < alloc_pct) begin
			r.req_type = REQ_ALLOC;
			if (issued_addrs.size() != 0 && $urandom_range(99) < 20)
				r.base_address = issued_addrs[$urandom_range(issued_addrs.size() - 1)];
			pick = $urandom_range(99);
			if (pick < 5) begin
				if ($urandom_range(1))
					r.elem_bytes = '0;
				else
					r.elem_count = '0;
			end else if (pick < 86) begin
				r.elem_bytes = $urandom_range(256, 1);
				r.elem_count = $urandom_range(1024, 1);
			end else if (pick < 96) begin
				r.elem_count = $urandom_range(16, 1);
			end
		end else begin
			r.req_type = REQ_FREE;
			pick = $urandom_range(99);
			if (issued_addrs.size() != 0) begin
				if (pick < 60)
					r.base_address = issued_addrs[$urandom_range(issued_addrs.size() - 1)];
				else if (pick < 75)
					r.base_address = issued_addrs[$];
			end
		end
		return r;
	endfunction

	task automatic offer(input req_t r);
		@(negedge clk);
		if (!(reqs_sent >= 700 && reqs_sent < 1000)) begin
			while ($urandom_range(99) < 34) begin
				req_valid <= 1'b0;
				@(negedge clk);
			end
		end
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		ledger.book(r);
		reqs_sent++;
		if (r.req_type == REQ_ALLOC && issued_addrs.size() < TABLE_DEPTH)
			issued_addrs.push_back(r.base_address);
	endtask

	initial begin : watchdog
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : drain
		int unsigned hold;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold--;
				rsp_ready <= 1'b0;
			end else if (rsps_seen >= 700 && rsps_seen < 1000) begin
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= ($urandom_range(99) >= 34);
			end
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				ledger.audit(rsp);
				rsps_seen++;
				if (rsps_seen == 400)
					hold = 900;
			end
		end
	end

	initial begin : stimulus
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		ledger = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, zero size, saturating add and subtract, double free, reuse
		offer(make_req(REQ_FREE, 48'h0, 32'h0, 32'h0));
		offer(make_req(REQ_ALLOC, 48'h0, 32'h0, 32'h0));
		offer(make_req(REQ_ALLOC, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		offer(make_req(REQ_ALLOC, 48'h0000_0000_1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		offer(make_req(REQ_FREE, 48'hFFFF_FFFF_FFFF, 32'h0, 32'h0));
		offer(make_req(REQ_FREE, 48'h0000_0000_1000, 32'h0, 32'h0));
		offer(make_req(REQ_FREE, 48'hFFFF_FFFF_FFFF, 32'h0, 32'h0));
		offer(make_req(REQ_ALLOC, 48'hFFFF_FFFF_FFFF, 32'd3, 32'd4096));
		offer(make_req(REQ_FREE, 48'hFFFF_FFFF_FFFF, 32'h0, 32'h0));
		offer(make_req(REQ_FREE, 48'h0, 32'h0, 32'h0));
		offer(make_req(REQ_FREE, 48'h0, 32'h0, 32'h0));
		offer(make_req(REQ_ALLOC, 48'hAAAA_AAAA_AAAA, 32'hFFFF_FFFF, 32'd1));
		offer(make_req(REQ_ALLOC, 48'h5555_5555_5555, 32'd1, 32'hFFFF_FFFF));
		offer(make_req(REQ_ALLOC, 48'h5555_5555_5554, 32'd1023, 32'd1));
		offer(make_req(REQ_FREE, 48'h5555_5555_5554, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		offer(make_req(REQ_FREE, 48'h5555_5555_5555, 32'h0, 32'h0));
		offer(make_req(REQ_FREE, 48'hAAAA_AAAA_AAAB, 32'h0, 32'h0));
		offer(make_req(REQ_ALLOC, 48'h0000_0000_2000, 32'h8000_0000, 32'h8000_0000));
		offer(make_req(REQ_FREE, 48'h0000_0000_2000, 32'h0, 32'h0));

		for (n = 0; n < 1880; n++)
			offer(random_req());
		@(negedge clk);
		req_valid <= 1'b0;

		while (ledger.due_reports.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (ledger.due_reports.size() != 0) begin
			ledger.faults++;
			$display("%0d responses never arrived", ledger.due_reports.size());
		end
		if (ledger.faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/att_pkg.sv
sv/att_cell.sv
sv/att_chain.sv
sv/allocation_tracking_table_core.sv
bench/att_ledger_pkg.sv
bench/testbench.sv
